@@ hdl/mi3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and cofactor index tables for the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEM       = 9;

  typedef logic [3:0] idx_t;

  // cofactor k = a[X]*a[Y] - a[U]*a[V], adjugate order (already transposed)
  localparam idx_t CF_X [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t CF_Y [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t CF_U [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t CF_V [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

@@ hdl/mi3_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Four-stage front end: element products, cofactors, split determinant
// partial products, determinant sum.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] elem [mi3_pkg::NUM_ELEM],
  output logic                         out_valid,
  output logic signed [2*DATA_WIDTH:0] cof [mi3_pkg::NUM_ELEM],
  output logic signed [3*DATA_WIDTH+2:0] det
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int PPW = 2 * W + 1;
  localparam int DTW = 3 * W + 3;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic signed [PW-1:0]  px_r [NUM_ELEM];
  logic signed [PW-1:0]  pu_r [NUM_ELEM];
  logic signed [W-1:0]   a1_r [3];
  logic signed [W-1:0]   a2_r [3];
  logic signed [CW-1:0]  c2_r [NUM_ELEM];
  logic signed [CW-1:0]  c3_r [NUM_ELEM];
  logic signed [CW-1:0]  c4_r [NUM_ELEM];
  logic signed [PPW-1:0] lo_r [3];
  logic signed [PPW-1:0] hi_r [3];
  logic signed [DTW-1:0] det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        px_r[k] <= PW'(elem[CF_X[k]]) * PW'(elem[CF_Y[k]]);
        pu_r[k] <= PW'(elem[CF_U[k]]) * PW'(elem[CF_V[k]]);
        c2_r[k] <= CW'(px_r[k]) - CW'(pu_r[k]);
        c3_r[k] <= c2_r[k];
        c4_r[k] <= c3_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        a1_r[j] <= elem[j];
        a2_r[j] <= a1_r[j];
        // det term a[j] * c[3j], cofactor split into low unsigned and high signed halves
        lo_r[j] <= PPW'(a2_r[j]) * PPW'($signed({1'b0, c2_r[3*j][W-1:0]}));
        hi_r[j] <= PPW'(a2_r[j]) * PPW'($signed(c2_r[3*j][CW-1:W]));
      end
      det_r <= (DTW'(hi_r[0]) <<< W) + DTW'(lo_r[0])
             + (DTW'(hi_r[1]) <<< W) + DTW'(lo_r[1])
             + (DTW'(hi_r[2]) <<< W) + DTW'(lo_r[2]);
    end
  end

  assign out_valid = v4_r;
  assign cof       = c4_r;
  assign det       = det_r;

endmodule

@@ hdl/mi3_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_divider
// Nine-lane restoring divider, one quotient bit per stage, sharing one
// determinant pipeline; truncates, saturates and flags a zero determinant.
// ----------------------------------------------------------------------------
module mi3_divider #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [2*DATA_WIDTH:0]   cof [mi3_pkg::NUM_ELEM],
  input  logic signed [3*DATA_WIDTH+2:0] det,
  output logic                           out_valid,
  output logic signed [DATA_WIDTH-1:0]   inv [mi3_pkg::NUM_ELEM],
  output logic                           singular
);
  import mi3_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int TW = NW - W;
  localparam int MW = (TW > DW) ? TW : DW;
  localparam int RW = DW + 1;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] QMAX = HALF - W'(1);

  // stage A: magnitudes and signs
  logic             va_r;
  logic [DW-1:0]    dmag_a_r;
  logic             dzero_a_r;
  logic [CW-1:0]    nmag_a_r [NUM_ELEM];
  logic             qneg_a_r [NUM_ELEM];

  // stage B and the quotient steps: index 0 is stage B
  logic             v_r     [W+1];
  logic [DW-1:0]    d_r     [W+1];
  logic             dzero_r [W+1];
  logic [DW-1:0]    rem_r   [W+1][NUM_ELEM];
  logic [W-1:0]     nq_r    [W+1][NUM_ELEM];
  logic             ovf_r   [W+1][NUM_ELEM];
  logic             qneg_r  [W+1][NUM_ELEM];

  // output register
  logic             vo_r;
  logic signed [W-1:0] inv_r [NUM_ELEM];
  logic             sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag_a_r  <= det[DW-1] ? DW'(-det) : DW'(det);
      dzero_a_r <= (det == '0);
      for (int k = 0; k < NUM_ELEM; k++) begin
        nmag_a_r[k] <= cof[k][CW-1] ? CW'(-cof[k]) : CW'(cof[k]);
        qneg_a_r[k] <= cof[k][CW-1] ^ det[DW-1];
      end
    end
  end

  // stage B: top of the scaled numerator decides overflow and seeds the remainder
  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_seed
    logic [NW-1:0] num;
    logic [TW-1:0] top;
    logic          big;
    assign num = {nmag_a_r[k], {(2*FRAC_BITS){1'b0}}};
    assign top = num[NW-1:W];
    assign big = MW'(top) >= MW'(dmag_a_r);
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[0][k]  <= big;
        rem_r[0][k]  <= big ? '0 : DW'(top);
        nq_r[0][k]   <= num[W-1:0];
        qneg_r[0][k] <= qneg_a_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]     <= dmag_a_r;
      dzero_r[0] <= dzero_a_r;
    end
  end

  // quotient steps: shift one numerator bit in, subtract when it fits
  for (genvar s = 0; s < W; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s+1]     <= d_r[s];
        dzero_r[s+1] <= dzero_r[s];
      end
    end

    for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
      logic [RW-1:0] sh;
      logic [RW-1:0] diff;
      logic          ge;
      assign sh   = {rem_r[s][k], nq_r[s][k][W-1]};
      assign ge   = sh >= RW'(d_r[s]);
      assign diff = sh - RW'(d_r[s]);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1][k]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
          nq_r[s+1][k]   <= {nq_r[s][k][W-2:0], ge};
          ovf_r[s+1][k]  <= ovf_r[s][k];
          qneg_r[s+1][k] <= qneg_r[s][k];
        end
      end
    end
  end

  // final: saturate, apply sign, zero out a singular matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= dzero_r[W];
      for (int k = 0; k < NUM_ELEM; k++) begin
        if (dzero_r[W]) begin
          inv_r[k] <= '0;
        end else if (qneg_r[W][k]) begin
          inv_r[k] <= (ovf_r[W][k] || nq_r[W][k] > HALF) ? HALF : (-nq_r[W][k]);
        end else begin
          inv_r[k] <= (ovf_r[W][k] || nq_r[W][k] > QMAX) ? QMAX : nq_r[W][k];
        end
      end
    end
  end

  assign out_valid = vo_r;
  assign inv       = inv_r;
  assign singular  = sing_r;

endmodule

@@ hdl/matrix_inverse_3x3_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 fixed-point inverse by adjugate and exact scaled division.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle unless a held result stalls the pipeline. Four
// stages form products, cofactors and the determinant, two stages take
// magnitudes and seed the division, then the quotient pipeline produces one
// bit per stage for all nine elements in parallel, and a last stage saturates
// into the output register. The depth of that one-bit-per-stage quotient
// pipeline sets the latency. A stall on the result side while a result is
// valid freezes the whole pipeline and is passed to in_stall.
// Quotients are truncated toward zero; a zero determinant gives all zeros
// with out_singular set.
module matrix_inverse_3x3_unit #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_a00,
  input  logic signed [DATA_WIDTH-1:0] in_a01,
  input  logic signed [DATA_WIDTH-1:0] in_a02,
  input  logic signed [DATA_WIDTH-1:0] in_a10,
  input  logic signed [DATA_WIDTH-1:0] in_a11,
  input  logic signed [DATA_WIDTH-1:0] in_a12,
  input  logic signed [DATA_WIDTH-1:0] in_a20,
  input  logic signed [DATA_WIDTH-1:0] in_a21,
  input  logic signed [DATA_WIDTH-1:0] in_a22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_inv00,
  output logic signed [DATA_WIDTH-1:0] out_inv01,
  output logic signed [DATA_WIDTH-1:0] out_inv02,
  output logic signed [DATA_WIDTH-1:0] out_inv10,
  output logic signed [DATA_WIDTH-1:0] out_inv11,
  output logic signed [DATA_WIDTH-1:0] out_inv12,
  output logic signed [DATA_WIDTH-1:0] out_inv20,
  output logic signed [DATA_WIDTH-1:0] out_inv21,
  output logic signed [DATA_WIDTH-1:0] out_inv22,
  output logic                         out_singular
);
  import mi3_pkg::*;

  logic                           en;
  logic                           f_valid;
  logic signed [DATA_WIDTH-1:0]   elem [NUM_ELEM];
  logic signed [2*DATA_WIDTH:0]   cof [NUM_ELEM];
  logic signed [3*DATA_WIDTH+2:0] det;
  logic signed [DATA_WIDTH-1:0]   inv [NUM_ELEM];

  // hold everything while a finished word waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign elem[0] = in_a00;
  assign elem[1] = in_a01;
  assign elem[2] = in_a02;
  assign elem[3] = in_a10;
  assign elem[4] = in_a11;
  assign elem[5] = in_a12;
  assign elem[6] = in_a20;
  assign elem[7] = in_a21;
  assign elem[8] = in_a22;

  mi3_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .elem     (elem),
    .out_valid(f_valid),
    .cof      (cof),
    .det      (det)
  );

  mi3_divider #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .cof      (cof),
    .det      (det),
    .out_valid(out_valid),
    .inv      (inv),
    .singular (out_singular)
  );

  assign out_inv00 = inv[0];
  assign out_inv01 = inv[1];
  assign out_inv02 = inv[2];
  assign out_inv10 = inv[3];
  assign out_inv11 = inv[4];
  assign out_inv12 = inv[5];
  assign out_inv20 = inv[6];
  assign out_inv21 = inv[7];
  assign out_inv22 = inv[8];

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv00 == '0 && out_inv01 == '0 && out_inv02 == '0
      && out_inv10 == '0 && out_inv11 == '0 && out_inv12 == '0
      && out_inv20 == '0 && out_inv21 == '0 && out_inv22 == '0)
    else $error("singular word carries nonzero elements");

  a_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && !f_valid)
    else $error("pipeline not empty after reset");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a held result");

endmodule
